[src/bts_pkg.sv]
// shared types and constants for the block time-step level selector
package bts_pkg;

   localparam int STEP_WIDTH  = 32;
   localparam int LEVEL_WIDTH = 5;
   localparam int NUM_LEVELS  = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CMP_WIDTH   = 128;

   localparam logic [CSR_IDX_W-1:0] REG_BASE_STEP       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ERROR_TOLERANCE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEEPEST_LEVEL   = 2'd2;

   typedef struct packed {
      logic [STEP_WIDTH-1:0]    base_step;
      logic [STEP_WIDTH-1:0]    error_tolerance;
      logic [LEVEL_WIDTH-1:0]   deepest_level;
      logic [2*STEP_WIDTH-1:0]  base_step_sq;
   } cfg_type;

endpackage

[src/bts_square.sv]
// magnitude and sum of squares of the acceleration vector, three stages
module bts_square
   import bts_pkg::*;
#(
   parameter int AW = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic signed [AW-1:0] accel_x,
   input  logic signed [AW-1:0] accel_y,
   input  logic signed [AW-1:0] accel_z,
   input  logic                batch_end,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [2*AW-1:0]     out_sum,
   output logic                out_batch_end
);

   localparam int HW = (AW + 1) / 2;
   localparam int SW = 2 * AW + 2;

   logic [2:0] v_ff;
   logic [2:0] be_ff;
   logic [2:0] adv;

   logic [AW-1:0]     mag_in [3];
   logic [AW-1:0]     mag_ff [3];
   logic [2*HW-1:0]   hh_ff [3];
   logic [2*HW-1:0]   hl_ff [3];
   logic [2*HW-1:0]   ll_ff [3];
   logic [SW-1:0]     sq [3];
   logic [SW-1:0]     sum_all;
   logic [2*AW-1:0]   sum_ff;

   assign adv[2] = !v_ff[2] || out_ready;
   assign adv[1] = !v_ff[1] || adv[2];
   assign adv[0] = !v_ff[0] || adv[1];
   assign in_ready = adv[0];

   // most negative value maps to 2^(AW-1), which fits unsigned
   assign mag_in[0] = accel_x[AW-1] ? (~accel_x + 1'b1) : accel_x;
   assign mag_in[1] = accel_y[AW-1] ? (~accel_y + 1'b1) : accel_y;
   assign mag_in[2] = accel_z[AW-1] ? (~accel_z + 1'b1) : accel_z;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sq[c] = (SW'(hh_ff[c]) << (2 * HW)) + (SW'(hl_ff[c]) << (HW + 1)) + SW'(ll_ff[c]);
      end
      sum_all = sq[0] + sq[1] + sq[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= in_valid;
         if (adv[1]) v_ff[1] <= v_ff[0];
         if (adv[2]) v_ff[2] <= v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         be_ff[0] <= batch_end;
         for (int c = 0; c < 3; c++) mag_ff[c] <= mag_in[c];
      end
      if (adv[1]) begin
         be_ff[1] <= be_ff[0];
         for (int c = 0; c < 3; c++) begin
            hh_ff[c] <= (2*HW)'(mag_ff[c][AW-1:HW]) * (2*HW)'(mag_ff[c][AW-1:HW]);
            hl_ff[c] <= (2*HW)'(mag_ff[c][AW-1:HW]) * (2*HW)'(mag_ff[c][HW-1:0]);
            ll_ff[c] <= (2*HW)'(mag_ff[c][HW-1:0]) * (2*HW)'(mag_ff[c][HW-1:0]);
         end
      end
      if (adv[2]) begin
         be_ff[2] <= be_ff[1];
         sum_ff   <= sum_all[2*AW-1:0];
      end
   end

   assign out_valid     = v_ff[2];
   assign out_sum       = sum_ff;
   assign out_batch_end = be_ff[2];

endmodule

[src/bts_sqrt.sv]
// pipelined floor square root, one result bit per stage
module bts_sqrt
   import bts_pkg::*;
#(
   parameter int AW = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [2*AW-1:0]   in_sum,
   input  logic              in_batch_end,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [AW-1:0]     out_root,
   output logic              out_batch_end
);

   localparam int RW = AW + 2;

   logic              v_ff    [AW];
   logic              be_ff   [AW];
   logic [RW-1:0]     rem_ff  [AW];
   logic [AW-1:0]     root_ff [AW];
   logic [2*AW-1:0]   n_ff    [AW];
   logic              rdy     [AW+1];

   assign rdy[AW] = out_ready;

   for (genvar i = 0; i < AW; i++) begin : g_stage
      logic            src_v;
      logic            src_be;
      logic [RW-1:0]   src_rem;
      logic [AW-1:0]   src_root;
      logic [2*AW-1:0] src_n;
      logic [RW+1:0]   cur;
      logic [RW+1:0]   trial;
      logic [RW+1:0]   diff;
      logic            ge;

      if (i == 0) begin : g_first
         assign src_v    = in_valid;
         assign src_be   = in_batch_end;
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_n    = in_sum;
      end else begin : g_next
         assign src_v    = v_ff[i-1];
         assign src_be   = be_ff[i-1];
         assign src_rem  = rem_ff[i-1];
         assign src_root = root_ff[i-1];
         assign src_n    = n_ff[i-1];
      end

      assign rdy[i] = !v_ff[i] || rdy[i+1];
      assign cur    = {src_rem, src_n[2*AW-1 -: 2]};
      assign trial  = (RW+2)'({src_root, 2'b01});
      assign ge     = cur >= trial;
      assign diff   = cur - trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            v_ff[i] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[i]) begin
            be_ff[i]   <= src_be;
            rem_ff[i]  <= ge ? diff[RW-1:0] : cur[RW-1:0];
            root_ff[i] <= {src_root[AW-2:0], ge};
            n_ff[i]    <= src_n << 2;
         end
      end
   end

   assign in_ready      = rdy[0];
   assign out_valid     = v_ff[AW-1];
   assign out_root      = root_ff[AW-1];
   assign out_batch_end = be_ff[AW-1];

endmodule

[src/bts_select.sv]
// product with the squared step, per-level compares and level pick
module bts_select
   import bts_pkg::*;
#(
   parameter int AW = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [AW-1:0]           in_acc,
   input  logic                    in_batch_end,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [LEVEL_WIDTH-1:0]  out_level,
   output logic [STEP_WIDTH-1:0]   out_size,
   output logic                    out_batch_end
);

   localparam int HW = (AW + 1) / 2;
   localparam int QW = STEP_WIDTH + HW;
   localparam int PW = 2 * STEP_WIDTH + AW;

   logic [3:0] v_ff;
   logic [3:0] be_ff;
   logic [3:0] adv;

   logic [AW-1:0]          acc_fix;
   logic [QW-1:0]          p_ff [4];
   logic [PW-1:0]          prod;
   logic [PW-1:0]          prod_ff;
   logic [CMP_WIDTH-1:0]   lhs;
   logic [NUM_LEVELS-1:0]  pass_in;
   logic [NUM_LEVELS-1:0]  pass_ff;
   logic [LEVEL_WIDTH-1:0] level_in;
   logic [LEVEL_WIDTH-1:0] level_ff;
   logic [STEP_WIDTH-1:0]  size_ff;
   logic [STEP_WIDTH-1:0]  dlo;
   logic [STEP_WIDTH-1:0]  dhi;

   assign adv[3] = !v_ff[3] || out_ready;
   assign adv[2] = !v_ff[2] || adv[3];
   assign adv[1] = !v_ff[1] || adv[2];
   assign adv[0] = !v_ff[0] || adv[1];
   assign in_ready = adv[0];

   // zero magnitude counts as one lsb
   assign acc_fix = (in_acc == '0) ? AW'(1) : in_acc;
   assign dlo     = cfg.base_step_sq[STEP_WIDTH-1:0];
   assign dhi     = cfg.base_step_sq[2*STEP_WIDTH-1:STEP_WIDTH];

   assign prod = PW'(p_ff[0]) + (PW'(p_ff[1]) << HW) + (PW'(p_ff[2]) << STEP_WIDTH)
               + (PW'(p_ff[3]) << (STEP_WIDTH + HW));
   assign lhs  = CMP_WIDTH'(prod_ff) << 2;

   // pass when 4*d^2*a <= e * 2^(2l+32)
   always_comb begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
         pass_in[l] = (lhs <= (CMP_WIDTH'(cfg.error_tolerance) << (2 * l + 32)))
                      && (LEVEL_WIDTH'(l) <= cfg.deepest_level);
      end
   end

   always_comb begin
      level_in = cfg.deepest_level;
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
         if (pass_ff[l]) level_in = LEVEL_WIDTH'(l);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= in_valid;
         if (adv[1]) v_ff[1] <= v_ff[0];
         if (adv[2]) v_ff[2] <= v_ff[1];
         if (adv[3]) v_ff[3] <= v_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         be_ff[0] <= in_batch_end;
         p_ff[0]  <= QW'(dlo) * QW'(acc_fix[HW-1:0]);
         p_ff[1]  <= QW'(dlo) * QW'(acc_fix[AW-1:HW]);
         p_ff[2]  <= QW'(dhi) * QW'(acc_fix[HW-1:0]);
         p_ff[3]  <= QW'(dhi) * QW'(acc_fix[AW-1:HW]);
      end
      if (adv[1]) begin
         be_ff[1] <= be_ff[0];
         prod_ff  <= prod;
      end
      if (adv[2]) begin
         be_ff[2] <= be_ff[1];
         pass_ff  <= pass_in;
      end
      if (adv[3]) begin
         be_ff[3] <= be_ff[2];
         level_ff <= level_in;
         size_ff  <= cfg.base_step >> level_in;
      end
   end

   assign out_valid     = v_ff[3];
   assign out_level     = level_ff;
   assign out_size      = size_ff;
   assign out_batch_end = be_ff[3];

endmodule

[src/block_timestep_level_select.sv]
// top level: configuration registers and the three pipeline sections
//
// One request carries a particle's acceleration (three signed Q16.16
// components of ACCEL_WIDTH bits) and a batch_end flag. One response
// returns the power-of-two subdivision level, base_step >> level and the
// copied batch_end flag, in request order.
// A request passes through the squares and their sum, the square
// root pipeline, then the product, the level compares and the
// output register. A new request is taken every cycle while
// req_stall is low.
// Each stage holds its own valid bit; when rsp_stall is high, bubbles
// still close up and requests keep entering until every stage is full,
// after which req_stall rises. Nothing is dropped or repeated.
// The configuration port writes base_step, error_tolerance and
// deepest_level by index; write only while no request is in flight.
// Synchronous reset empties the pipeline and restores the register
// defaults (1.0, 1.0 and level 8).
module block_timestep_level_select
   import bts_pkg::*;
#(
   parameter int ACCEL_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [ACCEL_WIDTH-1:0] req_accel_x,
   input  logic signed [ACCEL_WIDTH-1:0] req_accel_y,
   input  logic signed [ACCEL_WIDTH-1:0] req_accel_z,
   input  logic                          req_batch_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [LEVEL_WIDTH-1:0]        rsp_step_level,
   output logic [STEP_WIDTH-1:0]         rsp_step_size,
   output logic                          rsp_batch_end_out,
   input  logic                          csr_write,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [STEP_WIDTH-1:0]         csr_data
);

   logic [STEP_WIDTH-1:0]   base_ff;
   logic [STEP_WIDTH-1:0]   tol_ff;
   logic [LEVEL_WIDTH-1:0]  deep_ff;
   logic [2*STEP_WIDTH-1:0] dsq_ff;
   cfg_type                 cfg;

   logic                    sq_ready;
   logic                    sq_valid;
   logic [2*ACCEL_WIDTH-1:0] sq_sum;
   logic                    sq_be;
   logic                    rt_ready;
   logic                    rt_valid;
   logic [ACCEL_WIDTH-1:0]  rt_root;
   logic                    rt_be;
   logic                    sel_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= STEP_WIDTH'(65536);
         tol_ff  <= STEP_WIDTH'(65536);
         deep_ff <= LEVEL_WIDTH'(8);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_BASE_STEP:       base_ff <= csr_data;
            REG_ERROR_TOLERANCE: tol_ff  <= csr_data;
            REG_DEEPEST_LEVEL:   deep_ff <= csr_data[LEVEL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // squared base step follows the register in the next cycle
   always_ff @(posedge clock) begin
      dsq_ff <= (2*STEP_WIDTH)'(base_ff) * (2*STEP_WIDTH)'(base_ff);
   end

   assign cfg.base_step       = base_ff;
   assign cfg.error_tolerance = tol_ff;
   assign cfg.deepest_level   = deep_ff;
   assign cfg.base_step_sq    = dsq_ff;

   bts_square #(.AW(ACCEL_WIDTH)) u_square (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (sq_ready),
      .accel_x       (req_accel_x),
      .accel_y       (req_accel_y),
      .accel_z       (req_accel_z),
      .batch_end     (req_batch_end),
      .out_valid     (sq_valid),
      .out_ready     (rt_ready),
      .out_sum       (sq_sum),
      .out_batch_end (sq_be)
   );

   bts_sqrt #(.AW(ACCEL_WIDTH)) u_sqrt (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (sq_valid),
      .in_ready      (rt_ready),
      .in_sum        (sq_sum),
      .in_batch_end  (sq_be),
      .out_valid     (rt_valid),
      .out_ready     (sel_ready),
      .out_root      (rt_root),
      .out_batch_end (rt_be)
   );

   bts_select #(.AW(ACCEL_WIDTH)) u_select (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .in_valid      (rt_valid),
      .in_ready      (sel_ready),
      .in_acc        (rt_root),
      .in_batch_end  (rt_be),
      .out_valid     (rsp_valid),
      .out_ready     (!rsp_stall),
      .out_level     (rsp_step_level),
      .out_size      (rsp_step_size),
      .out_batch_end (rsp_batch_end_out)
   );

   assign req_stall = !sq_ready;

   // input backs up only when every stage is full and the output is held
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while the pipeline can still move");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_step_level <= deep_ff))
      else $error("level beyond deepest level");

   a_size_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_step_size == (base_ff >> rsp_step_level)))
      else $error("step size does not match level");

endmodule

[verif/block_timestep_level_select_test.sv]
// self-checking testbench for the block time-step level selector
module block_timestep_level_select_test;
   import bts_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AW = 32;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = AW + 20;
   localparam int RANDOM_ITEMS = 950;

   typedef struct {
      logic [LEVEL_WIDTH-1:0] level;
      logic [STEP_WIDTH-1:0]  size;
      logic                   last;
   } step_choice_type;

   typedef struct {
      logic signed [AW-1:0] ax, ay, az;
      logic                 last;
      bit                   typed;   // expected level typed in the row
      logic [LEVEL_WIDTH-1:0] level;
   } accel_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic signed [AW-1:0]   req_accel_x = '0, req_accel_y = '0, req_accel_z = '0;
   logic                   req_batch_end = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [LEVEL_WIDTH-1:0] rsp_step_level;
   logic [STEP_WIDTH-1:0]  rsp_step_size;
   logic                   rsp_batch_end_out;
   logic                   csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = REG_BASE_STEP;
   logic [STEP_WIDTH-1:0]  csr_data = '0;

   logic [STEP_WIDTH-1:0]  dt_reg = 32'd65536;
   logic [STEP_WIDTH-1:0]  tol_reg = 32'd65536;
   logic [LEVEL_WIDTH-1:0] max_level_reg = 5'd8;

   step_choice_type pending_steps[$];
   int  failures = 0;
   int  idle_cycles = 0;
   bit  stall_mode = 0;

   block_timestep_level_select #(.ACCEL_WIDTH(AW)) i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] abs_accel(logic signed [AW-1:0] v);
      logic [63:0] m;
      m = {{(64-AW){v[AW-1]}}, v};
      return v[AW-1] ? -m : m;
   endfunction

   function automatic step_choice_type choose_step(logic signed [AW-1:0] ax, ay, az,
                                                   logic last);
      logic [127:0] sq, cand, lhs, rhs;
      logic [63:0]  mx, my, mz, mag;
      step_choice_type c;
      mx = abs_accel(ax);
      my = abs_accel(ay);
      mz = abs_accel(az);
      sq = 128'(mx) * mx + 128'(my) * my + 128'(mz) * mz;
      mag = '0;
      for (int b = 49; b >= 0; b--) begin
         cand = 128'(mag | (64'd1 << b));
         if (cand * cand <= sq) mag = cand[63:0];
      end
      if (mag == 0) mag = 64'd1;
      lhs = (128'(dt_reg) * dt_reg * mag) << 2;
      c.level = max_level_reg;
      for (int l = max_level_reg; l >= 0; l--) begin
         rhs = 128'(tol_reg) << (2 * l + 32);
         if (lhs <= rhs) c.level = LEVEL_WIDTH'(l);
      end
      c.size = dt_reg >> c.level;
      c.last = last;
      return c;
   endfunction

   // one write, then csr_write is held low before the next
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [STEP_WIDTH-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_BASE_STEP:       dt_reg = val;
         REG_ERROR_TOLERANCE: tol_reg = val;
         default:             max_level_reg = val[LEVEL_WIDTH-1:0];
      endcase
      @(posedge clock);
   endtask

   task automatic drain;
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // holds one request until the block takes it
   task automatic send_request(accel_row_type r);
      req_valid     <= 1'b1;
      req_accel_x   <= r.ax;
      req_accel_y   <= r.ay;
      req_accel_z   <= r.az;
      req_batch_end <= r.last;
      do @(posedge clock); while (req_stall);
      if (r.typed) begin
         step_choice_type c;
         c.level = r.level;
         c.size = dt_reg >> r.level;
         c.last = r.last;
         pending_steps.push_back(c);
      end else begin
         pending_steps.push_back(choose_step(r.ax, r.ay, r.az, r.last));
      end
   endtask

   function automatic logic signed [AW-1:0] rand_accel();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 255) - 128;
         1: return $signed($urandom) >>> $urandom_range(0, 31);
         2: return {1'b1, {(AW-1){1'b0}}};
         default: return $urandom;
      endcase
   endfunction

   task automatic send_burst_run(int count);
      accel_row_type r;
      int sent;
      int gap;
      sent = 0;
      while (sent < count) begin
         int burst;
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < count; i++) begin
            r.ax = rand_accel();
            r.ay = rand_accel();
            r.az = rand_accel();
            r.last = 1'($urandom_range(0, 1));
            r.typed = 1'b0;
            r.level = '0;
            send_request(r);
            sent++;
         end
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   // receiver stall pattern: alternates open stretches and choppy stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
         rsp_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (pending_steps.size() != 0 || req_valid) begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("block_timestep_level_select: mismatch");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_steps.size() == 0) begin
               $display("%0t unexpected response level %0d size %h", $realtime,
                        rsp_step_level, rsp_step_size);
               failures++;
            end else begin
               step_choice_type e;
               e = pending_steps.pop_front();
               if (rsp_step_level !== e.level) begin
                  $display("%0t step_level expected %0d actual %0d", $realtime,
                           e.level, rsp_step_level);
                  failures++;
               end
               if (rsp_step_size !== e.size) begin
                  $display("%0t step_size expected %h actual %h", $realtime,
                           e.size, rsp_step_size);
                  failures++;
               end
               if (rsp_batch_end_out !== e.last) begin
                  $display("%0t batch_end_out expected %b actual %b", $realtime,
                           e.last, rsp_batch_end_out);
                  failures++;
               end
            end
         end
      end
   end

   localparam logic signed [AW-1:0] MAX_POS = {1'b0, {(AW-1){1'b1}}};
   localparam logic signed [AW-1:0] MIN_NEG = {1'b1, {(AW-1){1'b0}}};
   localparam logic signed [AW-1:0] ONE = 32'sd65536;

   accel_row_type directed_rows[10] = '{
      // zero acceleration is raised to one lsb: level 0 at reset settings
      '{0, 0, 0, 1'b0, 1, 5'd0},
      // acc 1.0 with dt 1, err 1: 4 <= 1? no, 4 <= 4 at level 1
      '{ONE, 0, 0, 1'b1, 1, 5'd1},
      '{0, -ONE, 0, 1'b0, 1, 5'd1},
      '{0, 0, ONE, 1'b1, 1, 5'd1},
      '{MAX_POS, MAX_POS, MAX_POS, 1'b0, 0, 5'd0},
      '{MIN_NEG, MIN_NEG, MIN_NEG, 1'b1, 0, 5'd0},
      '{MIN_NEG, 0, 0, 1'b0, 0, 5'd0},
      '{-1, -1, -1, 1'b1, 0, 5'd0},
      '{1, 1, 1, 1'b0, 0, 5'd0},
      '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F, 1'b1, 0, 5'd0}
   };

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_request(directed_rows[i]);
      req_valid <= 1'b0;
      drain();

      // extremes of the registers, then a spread of random settings
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               write_csr(REG_BASE_STEP, 32'hFFFF_FFFF);
               write_csr(REG_ERROR_TOLERANCE, 32'd1);
               write_csr(REG_DEEPEST_LEVEL, 32'd31);
            end
            1: begin
               write_csr(REG_BASE_STEP, 32'd1);
               write_csr(REG_ERROR_TOLERANCE, 32'hFFFF_FFFF);
               write_csr(REG_DEEPEST_LEVEL, 32'd0);
            end
            2: begin
               // zero tolerance clamps to the deepest level, zero step gives size 0
               write_csr(REG_ERROR_TOLERANCE, 32'd0);
               write_csr(REG_DEEPEST_LEVEL, 32'd17);
            end
            3: begin
               write_csr(REG_BASE_STEP, 32'd0);
               write_csr(REG_ERROR_TOLERANCE, 32'd65536);
            end
            default: begin
               write_csr(REG_BASE_STEP, $urandom >> $urandom_range(0, 24));
               write_csr(REG_ERROR_TOLERANCE, $urandom >> $urandom_range(0, 24));
               write_csr(REG_DEEPEST_LEVEL, $urandom_range(0, 31));
            end
         endcase
         send_burst_run(phase < 4 ? 60 : (RANDOM_ITEMS - 240) / 4);
         drain();
      end

      if (failures == 0) begin
         $display("block_timestep_level_select: match");
      end else begin
         $display("block_timestep_level_select: mismatch");
      end
      $finish;
   end

endmodule

[block_timestep_level_select.f]
src/bts_pkg.sv
src/bts_square.sv
src/bts_sqrt.sv
src/bts_select.sv
src/block_timestep_level_select.sv
verif/block_timestep_level_select_test.sv
